[rtl/core/ssv_pkg.sv]
`default_nettype none
package ssv_pkg;

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_KEYLEN,
		PH_KEY,
		PH_VALLEN,
		PH_VAL,
		PH_FLAG,
		PH_EXP,
		PH_DONE,
		PH_HALT
	} phase_t;

	typedef enum logic [1:0] {
		KIND_KEY,
		KIND_VAL,
		KIND_REC_END,
		KIND_STATUS
	} kind_t;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_SMALL   = 3'd1;
	localparam logic [2:0] ST_MAGIC   = 3'd2;
	localparam logic [2:0] ST_VERSION = 3'd3;
	localparam logic [2:0] ST_CRC     = 3'd4;
	localparam logic [2:0] ST_TRUNC   = 3'd5;
	localparam logic [2:0] ST_FLAG    = 3'd6;
	localparam logic [2:0] ST_EXTRA   = 3'd7;

	localparam logic CFG_MAGIC = 1'b0;
	localparam logic CFG_NOW   = 1'b1;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [4:0] HDR_VERSION  = 5'd4;
	localparam logic [4:0] HDR_OFFSET   = 5'd5;
	localparam logic [4:0] HDR_COUNT    = 5'd13;
	localparam logic [4:0] HDR_LAST     = 5'd16;
	localparam logic [4:0] MIN_FILE     = 5'd21;
	localparam logic [2:0] HOLD_BYTES   = 3'd4;
	localparam logic [2:0] RES_DEPTH    = 3'd4;
	localparam logic [2:0] RES_ROOM_MAX = 3'd1;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic        keep;
		logic [63:0] expiry_time;
		logic [2:0]  status;
		logic [63:0] wal_offset;
		logic [31:0] kept_count;
		logic        last;
	} res_t;

	// one byte of reflected CRC-32, LSB first
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/core/snapshot_stream_validator_unit.sv]
// Accepted input items are registered in the input stage and parsed from there into the result queue.
// Throughput: one input item per cycle while each item yields at most one result and the output takes
// results; otherwise the input is held until the 4-entry result queue drains to one entry or fewer.
// The result queue admits a new item only with at least three free entries.
// Reset (arst_n low, asynchronous) clears parse state, result queue and config registers.
`default_nettype none
module snapshot_stream_validator_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // in_byte
	input  wire logic         s_axis_tlast,   // is_last
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// data_byte[7:0] keep[8] expiry_time[72:9] status[75:73] wal_offset[139:76]
	// kept_count[171:140] zero pad[175:172]
	output logic [175:0]      m_axis_tdata,
	output logic [1:0]        m_axis_tuser,   // kind
	output logic              m_axis_tlast,   // last
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic         cfg_index,
	input  wire logic [63:0]  cfg_data
);

	// configuration
	logic [31:0] magic_word_q;
	logic [63:0] now_time_q;

	// input stage
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// parse state
	logic [31:0]          hold_q, hold_n;
	logic [2:0]           fill_q, fill_n;
	logic [31:0]          crc_q, crc_n;
	ssv_pkg::phase_t      phase_q, phase_n;
	logic [31:0]          fcnt_q, fcnt_n;
	logic [63:0]          asm_q, asm_n;
	logic                 v2_q, v2_n;
	logic [31:0]          hmagic_q, hmagic_n;
	logic [63:0]          offset_q, offset_n;
	logic [31:0]          left_q, left_n;
	logic [31:0]          kept_q, kept_n;
	logic [2:0]           err_q, err_n;
	logic [4:0]           total_q, total_n;

	// result queue
	ssv_pkg::res_t fifo_q [ssv_pkg::RES_DEPTH];
	logic [1:0]    wr_ptr_q, rd_ptr_q;
	logic [2:0]    cnt_q;
	ssv_pkg::res_t head;
	logic          pop;
	logic          proc;

	ssv_pkg::res_t res [3];
	logic [1:0]    n;

	logic [7:0]  b;
	logic [4:0]  idx;
	logic [31:0] len;
	logic        val_done;
	logic        rec_end;
	logic [63:0] rec_exp;
	logic        rec_keep;
	logic        do_fail;
	logic [2:0]  fail_code;
	logic [2:0]  st;

	assign cfg_ready     = 1'b1;
	assign proc          = vld_s1 && (cnt_q <= ssv_pkg::RES_ROOM_MAX);
	assign s_axis_tready = !vld_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q <= '0;
			now_time_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ssv_pkg::CFG_MAGIC: magic_word_q <= cfg_data[31:0];
				ssv_pkg::CFG_NOW:   now_time_q   <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			vld_s1 <= 1'b1;
		end else if (proc) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_comb begin
		hold_n   = hold_q;
		fill_n   = fill_q;
		crc_n    = crc_q;
		phase_n  = phase_q;
		fcnt_n   = fcnt_q;
		asm_n    = asm_q;
		v2_n     = v2_q;
		hmagic_n = hmagic_q;
		offset_n = offset_q;
		left_n   = left_q;
		kept_n   = kept_q;
		err_n    = err_q;
		total_n  = total_q;
		n        = 2'd0;
		for (int i = 0; i < 3; i++) begin
			res[i] = '0;
		end
		b         = hold_q[7:0];
		idx       = fcnt_q[4:0];
		len       = {b, asm_q[23:0]};
		val_done  = 1'b0;
		rec_end   = 1'b0;
		rec_exp   = '0;
		rec_keep  = 1'b0;
		do_fail   = 1'b0;
		fail_code = ssv_pkg::ST_OK;
		st        = ssv_pkg::ST_OK;

		if (proc) begin
			if (total_q < ssv_pkg::MIN_FILE) begin
				total_n = total_q + 5'd1;
			end

			// the oldest held byte leaves the hold and enters the body
			if (fill_q >= ssv_pkg::HOLD_BYTES) begin
				crc_n = ssv_pkg::crc_byte(crc_q, b);
				unique case (phase_q)
					ssv_pkg::PH_HEADER: begin
						fcnt_n = fcnt_q + 32'd1;
						if (idx < ssv_pkg::HDR_VERSION) begin
							for (int i = 0; i < 4; i++) begin
								if (idx == 5'(i)) hmagic_n[8*i +: 8] = b;
							end
							if (idx == 5'd3 && hmagic_n != magic_word_q) begin
								do_fail   = 1'b1;
								fail_code = ssv_pkg::ST_MAGIC;
							end
						end else if (idx == ssv_pkg::HDR_VERSION) begin
							if (b == 8'd1) begin
								v2_n = 1'b0;
							end else if (b == 8'd2) begin
								v2_n = 1'b1;
							end else begin
								do_fail   = 1'b1;
								fail_code = ssv_pkg::ST_VERSION;
							end
						end else if (idx < ssv_pkg::HDR_COUNT) begin
							for (int i = 0; i < 8; i++) begin
								if (idx == ssv_pkg::HDR_OFFSET + 5'(i)) offset_n[8*i +: 8] = b;
							end
						end else if (idx <= ssv_pkg::HDR_LAST) begin
							for (int i = 0; i < 4; i++) begin
								if (idx == ssv_pkg::HDR_COUNT + 5'(i)) left_n[8*i +: 8] = b;
							end
							if (idx == ssv_pkg::HDR_LAST) begin
								phase_n = (left_n != 32'd0) ? ssv_pkg::PH_KEYLEN : ssv_pkg::PH_DONE;
								fcnt_n  = '0;
								asm_n   = '0;
							end
						end
					end
					ssv_pkg::PH_KEYLEN, ssv_pkg::PH_VALLEN: begin
						for (int i = 0; i < 4; i++) begin
							if (fcnt_q[1:0] == 2'(i)) asm_n[8*i +: 8] = b;
						end
						fcnt_n = fcnt_q + 32'd1;
						if (fcnt_q == 32'd3) begin
							asm_n = '0;
							if (phase_q == ssv_pkg::PH_KEYLEN) begin
								if (len != 32'd0) begin
									phase_n = ssv_pkg::PH_KEY;
									fcnt_n  = len;
								end else begin
									phase_n = ssv_pkg::PH_VALLEN;
									fcnt_n  = '0;
								end
							end else if (len != 32'd0) begin
								phase_n = ssv_pkg::PH_VAL;
								fcnt_n  = len;
							end else begin
								val_done = 1'b1;
							end
						end
					end
					ssv_pkg::PH_KEY: begin
						res[n].kind      = ssv_pkg::KIND_KEY;
						res[n].data_byte = b;
						n                = n + 2'd1;
						fcnt_n           = fcnt_q - 32'd1;
						if (fcnt_n == 32'd0) begin
							phase_n = ssv_pkg::PH_VALLEN;
							asm_n   = '0;
						end
					end
					ssv_pkg::PH_VAL: begin
						res[n].kind      = ssv_pkg::KIND_VAL;
						res[n].data_byte = b;
						n                = n + 2'd1;
						fcnt_n           = fcnt_q - 32'd1;
						if (fcnt_n == 32'd0) val_done = 1'b1;
					end
					ssv_pkg::PH_FLAG: begin
						if (b == 8'd0) begin
							rec_end = 1'b1;
						end else if (b == 8'd1) begin
							phase_n = ssv_pkg::PH_EXP;
							fcnt_n  = '0;
							asm_n   = '0;
						end else begin
							do_fail   = 1'b1;
							fail_code = ssv_pkg::ST_FLAG;
						end
					end
					ssv_pkg::PH_EXP: begin
						for (int i = 0; i < 8; i++) begin
							if (fcnt_q[2:0] == 3'(i)) asm_n[8*i +: 8] = b;
						end
						fcnt_n = fcnt_q + 32'd1;
						if (fcnt_q == 32'd7) begin
							rec_end = 1'b1;
							rec_exp = asm_n;
						end
					end
					ssv_pkg::PH_DONE: begin
						do_fail   = 1'b1;
						fail_code = ssv_pkg::ST_EXTRA;
					end
					default: begin
					end
				endcase

				if (val_done) begin
					if (v2_q) begin
						phase_n = ssv_pkg::PH_FLAG;
						fcnt_n  = '0;
					end else begin
						rec_end = 1'b1;
					end
				end

				if (rec_end) begin
					rec_keep           = !(rec_exp != 64'd0 && rec_exp <= now_time_q);
					res[n].kind        = ssv_pkg::KIND_REC_END;
					res[n].keep        = rec_keep;
					res[n].expiry_time = rec_exp;
					n                  = n + 2'd1;
					if (rec_keep) kept_n = kept_q + 32'd1;
					left_n  = left_q - 32'd1;
					phase_n = (left_q != 32'd1) ? ssv_pkg::PH_KEYLEN : ssv_pkg::PH_DONE;
					fcnt_n  = '0;
					asm_n   = '0;
				end

				if (do_fail) begin
					if (err_q == ssv_pkg::ST_OK) err_n = fail_code;
					phase_n = ssv_pkg::PH_HALT;
				end
			end

			hold_n = {byte_s1, hold_q[31:8]};
			if (fill_q < ssv_pkg::HOLD_BYTES) fill_n = fill_q + 3'd1;

			if (last_s1) begin
				if (total_n < ssv_pkg::MIN_FILE) begin
					st = ssv_pkg::ST_SMALL;
				end else if (err_n == ssv_pkg::ST_MAGIC || err_n == ssv_pkg::ST_VERSION) begin
					st = err_n;
				end else if ((crc_n ^ ssv_pkg::CRC_INIT) != hold_n) begin
					st = ssv_pkg::ST_CRC;
				end else if (err_n != ssv_pkg::ST_OK) begin
					st = err_n;
				end else if (phase_n != ssv_pkg::PH_DONE) begin
					st = ssv_pkg::ST_TRUNC;
				end
				res[n].kind   = ssv_pkg::KIND_STATUS;
				res[n].status = st;
				if (st == ssv_pkg::ST_OK) begin
					res[n].wal_offset = offset_n;
					res[n].kept_count = kept_n;
				end
				n = n + 2'd1;

				hold_n   = '0;
				fill_n   = '0;
				crc_n    = ssv_pkg::CRC_INIT;
				phase_n  = ssv_pkg::PH_HEADER;
				fcnt_n   = '0;
				asm_n    = '0;
				v2_n     = 1'b0;
				hmagic_n = '0;
				offset_n = '0;
				left_n   = '0;
				kept_n   = '0;
				err_n    = ssv_pkg::ST_OK;
				total_n  = '0;
			end

			if (n != 2'd0) res[n - 2'd1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q   <= '0;
			fill_q   <= '0;
			crc_q    <= ssv_pkg::CRC_INIT;
			phase_q  <= ssv_pkg::PH_HEADER;
			fcnt_q   <= '0;
			asm_q    <= '0;
			v2_q     <= 1'b0;
			hmagic_q <= '0;
			offset_q <= '0;
			left_q   <= '0;
			kept_q   <= '0;
			err_q    <= ssv_pkg::ST_OK;
			total_q  <= '0;
		end else begin
			hold_q   <= hold_n;
			fill_q   <= fill_n;
			crc_q    <= crc_n;
			phase_q  <= phase_n;
			fcnt_q   <= fcnt_n;
			asm_q    <= asm_n;
			v2_q     <= v2_n;
			hmagic_q <= hmagic_n;
			offset_q <= offset_n;
			left_q   <= left_n;
			kept_q   <= kept_n;
			err_q    <= err_n;
			total_q  <= total_n;
		end
	end

	// result queue: up to three pushes, one pop per cycle
	assign head          = fifo_q[rd_ptr_q];
	assign m_axis_tvalid = (cnt_q != 3'd0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last;
	assign m_axis_tdata  = {4'd0, head.kept_count, head.wal_offset, head.status,
		head.expiry_time, head.keep, head.data_byte};

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (2'(k) < n) fifo_q[wr_ptr_q + 2'(k)] <= res[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, n} - {2'd0, pop};
		end
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ssv_pkg::RES_DEPTH)
		else $error("result queue overflow");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ssv_pkg::KIND_STATUS |-> m_axis_tlast)
		else $error("file status item without last");

	a_permanent_kept: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ssv_pkg::KIND_REC_END && head.expiry_time == 64'd0
		|-> head.keep)
		else $error("permanent record dropped");

	a_clear_after_file: assert property (@(posedge clk) disable iff (!arst_n)
		proc && last_s1 |=> phase_q == ssv_pkg::PH_HEADER && fill_q == 3'd0 && total_q == 5'd0)
		else $error("state not cleared after final byte");

endmodule
`default_nettype wire

[dv/snapshot_stream_validator_unit_tb.sv]
`timescale 1ns / 100ps
module snapshot_stream_validator_unit_tb;
	import ssv_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS_PER_PHASE = 100;

	typedef enum logic [3:0] {
		FLAW_NONE,
		FLAW_SHORT,
		FLAW_MAGIC,
		FLAW_VERSION,
		FLAW_CRC,
		FLAW_TRUNC,
		FLAW_FLAG,
		FLAW_EXTRA,
		FLAW_HUGE,
		FLAW_MAGIC_CRC,
		FLAW_FLAG_CRC,
		FLAW_NOISE
	} flaw_t;

	typedef struct packed {
		logic [7:0] ver;
		logic [3:0] nrec;
		flaw_t      flaw;
		logic [4:0] cut;
		logic       typed;
		logic [2:0] status;
	} scenario_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = '0;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [175:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic         cfg_index = CFG_MAGIC;
	logic [63:0]  cfg_data = '0;

	// register copies, updated on each accepted write
	logic [31:0] cfg_magic_word = '0;
	logic [63:0] cfg_now_time = '0;

	// parser state of the snapshot file in flight
	logic [31:0] tail_win;
	logic [2:0]  tail_fill;
	logic [31:0] crc_acc;
	phase_t      parse_ph;
	logic [31:0] fld_cnt;
	logic [63:0] acc64;
	logic        is_v2;
	logic [31:0] hdr_magic;
	logic [63:0] hdr_wal;
	logic [31:0] recs_left;
	logic [31:0] kept_recs;
	logic [2:0]  err_code;
	logic [4:0]  file_len;

	res_t        parse_results_q[$];
	logic [7:0]  file_q[$];

	logic        typed_valid = 1'b0;
	logic [2:0]  typed_code = ST_OK;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          items_sent = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;

	scenario_t directed_rows [0:16] = '{
		'{8'd1,  4'd0, FLAW_SHORT,     5'd1,  1'b1, ST_SMALL},
		'{8'd2,  4'd0, FLAW_SHORT,     5'd20, 1'b1, ST_SMALL},
		'{8'd1,  4'd0, FLAW_NONE,      5'd0,  1'b0, ST_OK},
		'{8'd1,  4'd3, FLAW_NONE,      5'd0,  1'b0, ST_OK},
		'{8'd2,  4'd4, FLAW_NONE,      5'd0,  1'b0, ST_OK},
		'{8'd2,  4'd0, FLAW_NONE,      5'd0,  1'b0, ST_OK},
		'{8'd1,  4'd1, FLAW_MAGIC,     5'd0,  1'b1, ST_MAGIC},
		'{8'd0,  4'd1, FLAW_VERSION,   5'd0,  1'b1, ST_VERSION},
		'{8'd3,  4'd1, FLAW_VERSION,   5'd0,  1'b1, ST_VERSION},
		'{8'hFF, 4'd0, FLAW_VERSION,   5'd0,  1'b1, ST_VERSION},
		'{8'd2,  4'd2, FLAW_CRC,       5'd0,  1'b1, ST_CRC},
		'{8'd1,  4'd1, FLAW_TRUNC,     5'd0,  1'b1, ST_TRUNC},
		'{8'd2,  4'd2, FLAW_FLAG,      5'd0,  1'b1, ST_FLAG},
		'{8'd1,  4'd1, FLAW_EXTRA,     5'd0,  1'b1, ST_EXTRA},
		'{8'd2,  4'd1, FLAW_HUGE,      5'd0,  1'b1, ST_TRUNC},
		'{8'd1,  4'd1, FLAW_MAGIC_CRC, 5'd0,  1'b1, ST_MAGIC},
		'{8'd2,  4'd1, FLAW_FLAG_CRC,  5'd0,  1'b1, ST_CRC}
	};

	snapshot_stream_validator_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
		int k;
		c = c ^ {24'd0, b};
		for (k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

	function automatic void clear_parse();
		tail_win = '0;
		tail_fill = '0;
		crc_acc = CRC_INIT;
		parse_ph = PH_HEADER;
		fld_cnt = '0;
		acc64 = '0;
		is_v2 = 1'b0;
		hdr_magic = '0;
		hdr_wal = '0;
		recs_left = '0;
		kept_recs = '0;
		err_code = ST_OK;
		file_len = '0;
	endfunction

	function automatic res_t make_res(kind_t k);
		res_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	function automatic void halt_parse(logic [2:0] code);
		if (err_code == ST_OK) begin
			err_code = code;
		end
		parse_ph = PH_HALT;
	endfunction

	function automatic void close_record(logic [63:0] expiry);
		res_t r;
		r = make_res(KIND_REC_END);
		r.keep = !(expiry != 0 && expiry <= cfg_now_time);
		r.expiry_time = expiry;
		if (r.keep) begin
			kept_recs++;
		end
		parse_results_q.push_back(r);
		recs_left--;
		parse_ph = (recs_left != 0) ? PH_KEYLEN : PH_DONE;
		fld_cnt = '0;
		acc64 = '0;
	endfunction

	function automatic void value_finished();
		if (is_v2) begin
			parse_ph = PH_FLAG;
			fld_cnt = '0;
		end else begin
			close_record('0);
		end
	endfunction

	// advance the parser by one file byte and queue the result items it yields
	function automatic void parse_file_byte(logic [7:0] b, logic fin);
		logic [7:0]  body;
		logic [31:0] len;
		logic [31:0] idx;
		logic [2:0]  code;
		int          n0;
		res_t        r;
		n0 = parse_results_q.size();
		if (file_len < MIN_FILE) begin
			file_len++;
		end
		// the oldest held byte leaves the checksum window and joins the body
		if (tail_fill >= HOLD_BYTES) begin
			body = tail_win[7:0];
			crc_acc = crc_update(crc_acc, body);
			case (parse_ph)
				PH_HEADER: begin
					idx = fld_cnt;
					fld_cnt++;
					if (idx < HDR_VERSION) begin
						hdr_magic |= {24'd0, body} << (8 * idx);
						if (idx == HDR_VERSION - 1 && hdr_magic != cfg_magic_word) begin
							halt_parse(ST_MAGIC);
						end
					end else if (idx == HDR_VERSION) begin
						if (body == 8'd1) begin
							is_v2 = 1'b0;
						end else if (body == 8'd2) begin
							is_v2 = 1'b1;
						end else begin
							halt_parse(ST_VERSION);
						end
					end else if (idx < HDR_COUNT) begin
						hdr_wal |= {56'd0, body} << (8 * (idx - HDR_OFFSET));
					end else if (idx <= HDR_LAST) begin
						recs_left |= {24'd0, body} << (8 * (idx - HDR_COUNT));
						if (idx == HDR_LAST) begin
							parse_ph = (recs_left != 0) ? PH_KEYLEN : PH_DONE;
							fld_cnt = '0;
							acc64 = '0;
						end
					end
				end
				PH_KEYLEN, PH_VALLEN: begin
					acc64 |= {56'd0, body} << (8 * fld_cnt[1:0]);
					fld_cnt++;
					if (fld_cnt >= 4) begin
						len = acc64[31:0];
						acc64 = '0;
						if (parse_ph == PH_KEYLEN) begin
							if (len != 0) begin
								parse_ph = PH_KEY;
								fld_cnt = len;
							end else begin
								parse_ph = PH_VALLEN;
								fld_cnt = '0;
							end
						end else if (len != 0) begin
							parse_ph = PH_VAL;
							fld_cnt = len;
						end else begin
							value_finished();
						end
					end
				end
				PH_KEY: begin
					r = make_res(KIND_KEY);
					r.data_byte = body;
					parse_results_q.push_back(r);
					fld_cnt--;
					if (fld_cnt == 0) begin
						parse_ph = PH_VALLEN;
						acc64 = '0;
					end
				end
				PH_VAL: begin
					r = make_res(KIND_VAL);
					r.data_byte = body;
					parse_results_q.push_back(r);
					fld_cnt--;
					if (fld_cnt == 0) begin
						value_finished();
					end
				end
				PH_FLAG: begin
					if (body == 8'd0) begin
						close_record('0);
					end else if (body == 8'd1) begin
						parse_ph = PH_EXP;
						fld_cnt = '0;
						acc64 = '0;
					end else begin
						halt_parse(ST_FLAG);
					end
				end
				PH_EXP: begin
					acc64 |= {56'd0, body} << (8 * fld_cnt[2:0]);
					fld_cnt++;
					if (fld_cnt >= 8) begin
						close_record(acc64);
					end
				end
				PH_DONE: halt_parse(ST_EXTRA);
				default: ;
			endcase
		end
		tail_win = {b, tail_win[31:8]};
		if (tail_fill < HOLD_BYTES) begin
			tail_fill++;
		end
		if (fin) begin
			if (file_len < MIN_FILE) begin
				code = ST_SMALL;
			end else if (err_code == ST_MAGIC || err_code == ST_VERSION) begin
				code = err_code;
			end else if (~crc_acc != tail_win) begin
				code = ST_CRC;
			end else if (err_code != ST_OK) begin
				code = err_code;
			end else if (parse_ph != PH_DONE) begin
				code = ST_TRUNC;
			end else begin
				code = ST_OK;
			end
			r = make_res(KIND_STATUS);
			r.status = code;
			if (code == ST_OK) begin
				r.wal_offset = hdr_wal;
				r.kept_count = kept_recs;
			end
			parse_results_q.push_back(r);
			clear_parse();
		end
		if (parse_results_q.size() > n0) begin
			r = parse_results_q[parse_results_q.size() - 1];
			r.last = 1'b1;
			parse_results_q[parse_results_q.size() - 1] = r;
		end
	endfunction

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		res_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (parse_results_q.size() == 0) begin
					$error("unexpected result item, kind %0d", m_axis_tuser);
					mismatches++;
				end else begin
					want = parse_results_q.pop_front();
					compare_field("kind", want.kind, m_axis_tuser);
					compare_field("data_byte", want.data_byte, m_axis_tdata[7:0]);
					compare_field("keep", want.keep, m_axis_tdata[8]);
					compare_field("expiry_time", want.expiry_time, m_axis_tdata[72:9]);
					compare_field("status", want.status, m_axis_tdata[75:73]);
					compare_field("wal_offset", want.wal_offset, m_axis_tdata[139:76]);
					compare_field("kept_count", want.kept_count, m_axis_tdata[171:140]);
					compare_field("last", want.last, m_axis_tlast);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MAGIC) begin
					cfg_magic_word = cfg_data[31:0];
				end else begin
					cfg_now_time = cfg_data;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				parse_file_byte(s_axis_tdata, s_axis_tlast);
				// typed directed rows carry their file status in the table
				if (s_axis_tlast && typed_valid) begin
					want = parse_results_q[parse_results_q.size() - 1];
					want.status = typed_code;
					want.wal_offset = '0;
					want.kept_count = '0;
					parse_results_q[parse_results_q.size() - 1] = want;
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic void append_le(logic [63:0] v, int nbytes);
		int i;
		for (i = 0; i < nbytes; i++) begin
			file_q.push_back(v[8 * i +: 8]);
		end
	endfunction

	function automatic logic [63:0] pick_expiry();
		case ($urandom_range(5))
			0: return 64'd0;
			1: return cfg_now_time;
			2: return cfg_now_time + 64'd1;
			3: return cfg_now_time - 64'd1;
			4: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// lay out one snapshot file in file_q, with the requested defect
	function automatic void build_file(logic [7:0] ver, int nrec, flaw_t flaw, int maxlen,
			int cut);
		logic [31:0] magic;
		logic [31:0] crc;
		int          rec;
		int          klen;
		int          vlen;
		file_q.delete();
		if (flaw == FLAW_NOISE) begin
			repeat ($urandom_range(1, 40)) file_q.push_back(8'($urandom));
			return;
		end
		magic = cfg_magic_word;
		if (flaw == FLAW_MAGIC || flaw == FLAW_MAGIC_CRC) begin
			magic ^= 32'd1 << $urandom_range(31);
		end
		append_le(magic, 4);
		append_le(ver, 1);
		append_le({$urandom, $urandom}, 8);
		append_le(nrec + (flaw == FLAW_TRUNC), 4);
		for (rec = 0; rec < nrec; rec++) begin
			if (flaw == FLAW_HUGE && rec == nrec - 1) begin
				append_le(32'hFFFF_FF00 | $urandom_range(255), 4);
				repeat (3) file_q.push_back(8'($urandom));
				break;
			end
			klen = $urandom_range(maxlen);
			append_le(klen, 4);
			repeat (klen) file_q.push_back(8'($urandom));
			vlen = $urandom_range(maxlen);
			append_le(vlen, 4);
			repeat (vlen) file_q.push_back(8'($urandom));
			if (ver == 8'd2) begin
				if ((flaw == FLAW_FLAG || flaw == FLAW_FLAG_CRC) && rec == nrec - 1) begin
					append_le($urandom_range(2, 255), 1);
				end else if ($urandom_range(1) == 1) begin
					append_le(1, 1);
					append_le(pick_expiry(), 8);
				end else begin
					append_le(0, 1);
				end
			end
		end
		if (flaw == FLAW_EXTRA) begin
			repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom));
		end
		crc = CRC_INIT;
		foreach (file_q[i]) begin
			crc = crc_update(crc, file_q[i]);
		end
		crc = ~crc;
		if (flaw == FLAW_CRC || flaw == FLAW_MAGIC_CRC || flaw == FLAW_FLAG_CRC) begin
			crc ^= 32'd1 << $urandom_range(31);
		end
		append_le(crc, 4);
		if (flaw == FLAW_SHORT) begin
			while (file_q.size() > cut) void'(file_q.pop_back());
		end
	endfunction

	task automatic push_file_byte(logic [7:0] b, logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= fin;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic run_file(logic typed, logic [2:0] code);
		typed_valid <= typed;
		typed_code <= code;
		foreach (file_q[i]) begin
			push_file_byte(file_q[i], i == file_q.size() - 1);
		end
		items_sent += file_q.size();
	endtask

	// hold the stream until every queued result item is out, then let the pipe settle
	task automatic wait_for_drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (parse_results_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_registers(logic [31:0] magic, logic [63:0] now);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_MAGIC;
		cfg_data <= {32'd0, magic};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_NOW;
		cfg_data <= now;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int send_pct, int recv_pct, logic [31:0] magic,
			logic [63:0] now);
		int         start;
		flaw_t      flaw;
		logic [7:0] ver;
		int         nrec;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		set_registers(magic, now);
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS_PER_PHASE) begin
			// mostly well-formed files, the rest defective or noise
			if ($urandom_range(99) < 60) begin
				flaw = FLAW_NONE;
			end else begin
				flaw = flaw_t'($urandom_range(FLAW_SHORT, FLAW_NOISE));
			end
			if (flaw == FLAW_VERSION) begin
				do ver = 8'($urandom); while (ver == 8'd1 || ver == 8'd2);
			end else if (flaw == FLAW_FLAG || flaw == FLAW_FLAG_CRC) begin
				ver = 8'd2;
			end else begin
				ver = 8'($urandom_range(1, 2));
			end
			nrec = $urandom_range(3);
			if (nrec == 0 && (flaw == FLAW_FLAG || flaw == FLAW_FLAG_CRC
					|| flaw == FLAW_HUGE)) begin
				nrec = 1;
			end
			build_file(ver, nrec, flaw, ($urandom_range(9) == 0) ? 24 : 4,
				$urandom_range(1, 20));
			run_file(1'b0, ST_OK);
			if ($urandom_range(4) == 0) begin
				wait_for_drain();
			end
		end
		wait_for_drain();
	endtask

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		clear_parse();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 24;
		recv_idle_pct = 81;
		set_registers(32'hFFFF_FFFF, 64'd1000);
		foreach (directed_rows[i]) begin
			build_file(directed_rows[i].ver, directed_rows[i].nrec, directed_rows[i].flaw, 3,
				directed_rows[i].cut);
			run_file(directed_rows[i].typed, directed_rows[i].status);
		end
		wait_for_drain();
		random_phase(24, 81, $urandom, {$urandom, $urandom});
		random_phase(81, 24, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
		random_phase(0, 0, 32'h8000_0001, 64'd0);
		repeat (8) @(posedge clk);
		if (parse_results_q.size() != 0) begin
			$error("%0d result items never arrived", parse_results_q.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
